/* rtl/tkti_pkg.sv */
// Shared constants, types and arithmetic helpers for the trilinear kernel table.
`timescale 1ns / 1ps
package tkti_pkg;

   localparam int GRID_POINTS = 32;
   localparam int HALF_POINTS = (GRID_POINTS + 1) / 2;
   localparam int TABLE_DEPTH = GRID_POINTS * GRID_POINTS * GRID_POINTS;
   localparam int BANK_DEPTH  = HALF_POINTS * HALF_POINTS * HALF_POINTS;
   localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int IDX_W       = $clog2(GRID_POINTS);
   localparam int CELL_MAX    = GRID_POINTS - 2;
   localparam int NUM_BANKS   = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [23:0] EIGHTH_Q24 = 24'd2097152;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_WRITE  = 2'd1,
      STATUS_NOLOAD = 2'd2
   } status_type;

   typedef logic [BANK_AW-1:0] bank_addr_type;

   // One classified item between front and back
   typedef struct packed {
      logic                           query;
      logic                           eighth;
      logic                           neg;
      logic [16:0]                    tx;
      logic [16:0]                    ty;
      logic [16:0]                    tz;
      logic [2:0]                     par;
      bank_addr_type [NUM_BANKS-1:0]  raddr;
      logic [2:0]                     wbank;
      bank_addr_type                  waddr;
      logic [23:0]                    wdata;
      logic                           wen;
      logic                           wlast;
   } entry_type;

   // ((1 - t) * a + t * b) >> 16, t in Q0.16 up to 1.0
   function automatic logic [23:0] blend(logic [23:0] a, logic [23:0] b, logic [16:0] t);
      logic [41:0] sum;
      sum = 42'(ONE_Q16 - t) * 42'(a) + 42'(t) * 42'(b);
      return sum[39:16];
   endfunction

endpackage

/* rtl/tkti_bank_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tkti_bank_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 24
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write and read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tkti_front.sv */
// Front end: accepts items, splits coordinates into cells and bank addresses.
`timescale 1ns / 1ps
module tkti_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [95:0]         req_tdata,
   input  logic [0:0]          req_tuser,
   output logic                push_valid,
   input  logic                push_ready,
   output tkti_pkg::entry_type push_entry
);
   import tkti_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] base;
      logic [16:0]      frac;
   } split_type;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;

   logic signed [17:0] xc, yc, zc;
   logic [16:0]        mx, my, mz;
   split_type          sx, sy, sz;
   logic [14:0]        waddr;
   logic [IDX_W-1:0]   wi, wj, wk;

   function automatic logic [16:0] mag_clamp(logic signed [17:0] c);
      logic [17:0] m;
      m = c[17] ? 18'(-c) : 18'(c);
      return (m > 18'(ONE_Q16)) ? ONE_Q16 : m[16:0];
   endfunction

   function automatic split_type split(logic [16:0] m);
      logic [22:0] a;
      logic [6:0]  c;
      split_type   s;
      a = 23'(m) * 23'(GRID_POINTS - 1);
      c = a[22:16];
      if (c > 7'(CELL_MAX)) begin
         c = 7'(CELL_MAX);
      end
      s.base = IDX_W'(c);
      s.frac = 17'(a - {c, 16'd0});
      return s;
   endfunction

   function automatic bank_addr_type bank_addr(logic [IDX_W-1:0] i, logic [IDX_W-1:0] j,
                                              logic [IDX_W-1:0] k);
      int unsigned hi, hj, hk;
      hi = 32'(i >> 1);
      hj = 32'(j >> 1);
      hk = 32'(k >> 1);
      return BANK_AW'(hi + HALF_POINTS * hj + HALF_POINTS * HALF_POINTS * hk);
   endfunction

   // Pick the corner index that lands in the bank of the given parity
   function automatic logic [IDX_W-1:0] pick(logic [IDX_W-1:0] c, logic p);
      return (c[0] == p) ? c : IDX_W'(c + 1'b1);
   endfunction

   assign req_tready = !valid_ff || push_ready;

   // Classify the incoming item
   always_comb begin
      xc    = req_tdata[56:39];
      yc    = req_tdata[74:57];
      zc    = req_tdata[92:75];
      waddr = req_tdata[14:0];
      mx    = mag_clamp(xc);
      my    = mag_clamp(yc);
      mz    = mag_clamp(zc);
      sx    = split(mx);
      sy    = split(my);
      sz    = split(mz);
      wi    = IDX_W'(waddr % 15'(GRID_POINTS));
      wj    = IDX_W'((waddr / 15'(GRID_POINTS)) % 15'(GRID_POINTS));
      wk    = IDX_W'(waddr / 15'(GRID_POINTS * GRID_POINTS));

      entry_in.query  = req_tuser[0];
      entry_in.eighth = (mx == ONE_Q16) && (my == ONE_Q16) && (mz == ONE_Q16);
      entry_in.neg    = xc[17] ^ yc[17] ^ zc[17];
      entry_in.tx     = sx.frac;
      entry_in.ty     = sy.frac;
      entry_in.tz     = sz.frac;
      entry_in.par    = {sz.base[0], sy.base[0], sx.base[0]};
      for (int d = 0; d < NUM_BANKS; d++) begin
         entry_in.raddr[d] = bank_addr(pick(sx.base, d[0]), pick(sy.base, d[1]),
                                       pick(sz.base, d[2]));
      end
      entry_in.wbank  = {wk[0], wj[0], wi[0]};
      entry_in.waddr  = bank_addr(wi, wj, wk);
      entry_in.wdata  = req_tdata[38:15];
      entry_in.wen    = !req_tuser[0] && (32'(waddr) < TABLE_DEPTH);
      entry_in.wlast  = (32'(waddr) == TABLE_DEPTH - 1);

      valid_in = req_tready ? req_tvalid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tready) begin
         entry_ff <= entry_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

/* rtl/tkti_queue.sv */
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module tkti_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tkti_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output tkti_pkg::entry_type pop_entry
);
   import tkti_pkg::*;

   entry_type  slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/tkti_back.sv */
// Back end: banked table, corner reads and the three blend stages.
`timescale 1ns / 1ps
module tkti_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  tkti_pkg::entry_type pop_entry,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser
);
   import tkti_pkg::*;

   typedef struct packed {
      status_type  status;
      logic        eighth;
      logic        neg;
      logic [16:0] ty;
      logic [16:0] tz;
   } ctl_type;

   logic       adv, take;
   logic       loaded_ff, loaded_in;
   logic [3:0] valid_ff;

   ctl_type     ctl1_in, ctl1_ff, ctl2_ff, ctl3_ff;
   logic [16:0] tx1_ff;
   logic [2:0]  par1_ff;
   logic [23:0] rd_data [NUM_BANKS];
   logic [23:0] corner [NUM_BANKS];
   logic [23:0] vx_ff [4];
   logic [23:0] vy_ff [2];
   logic [23:0] mag;
   logic [22:0] value_ff, value_in;
   status_type  status_ff;

   // Whole back pipeline moves when the output is free or taken
   assign adv       = !valid_ff[3] || rsp_tready;
   assign pop_ready = adv;
   assign take      = adv && pop_valid;

   // One bank per corner parity
   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      tkti_bank_ram #(
         .DEPTH (BANK_DEPTH),
         .AW    (BANK_AW),
         .DW    (24)
      ) u_ram (
         .clock   (clock),
         .wr_en   (take && pop_entry.wen && (pop_entry.wbank == 3'(b))),
         .wr_addr (pop_entry.waddr),
         .wr_data (pop_entry.wdata),
         .rd_en   (adv),
         .rd_addr (pop_entry.raddr[b]),
         .rd_data (rd_data[b])
      );
   end

   // Classify at the point of table access so writes and queries stay ordered
   always_comb begin
      loaded_in = loaded_ff || (take && pop_entry.wen && pop_entry.wlast);
      if (!pop_entry.query) begin
         ctl1_in.status = STATUS_WRITE;
      end else if (!loaded_ff) begin
         ctl1_in.status = STATUS_NOLOAD;
      end else begin
         ctl1_in.status = STATUS_OK;
      end
      ctl1_in.eighth = pop_entry.eighth;
      ctl1_in.neg    = pop_entry.neg;
      ctl1_in.ty     = pop_entry.ty;
      ctl1_in.tz     = pop_entry.tz;
   end

   // Route bank outputs back to corner order
   always_comb begin
      for (int d = 0; d < NUM_BANKS; d++) begin
         corner[d] = rd_data[3'(d) ^ par1_ff];
      end
   end

   // Final blend, saturate and apply sign; a status other than OK gives zero
   always_comb begin
      mag = blend(vy_ff[0], vy_ff[1], ctl3_ff.tz);
      if (mag > EIGHTH_Q24) begin
         mag = EIGHTH_Q24;
      end
      if (ctl3_ff.eighth) begin
         mag = EIGHTH_Q24;
      end
      if (ctl3_ff.status != STATUS_OK) begin
         value_in = 23'd0;
      end else if (ctl3_ff.neg) begin
         value_in = 23'(-mag);
      end else begin
         value_in = mag[22:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 4'd0;
         loaded_ff <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         if (adv) begin
            valid_ff <= {valid_ff[2:0], pop_valid};
         end
      end
      if (adv) begin
         ctl1_ff <= ctl1_in;
         tx1_ff  <= pop_entry.tx;
         par1_ff <= pop_entry.par;
         // Blend along x
         for (int p = 0; p < 4; p++) begin
            vx_ff[p] <= blend(corner[2 * p], corner[2 * p + 1], tx1_ff);
         end
         ctl2_ff <= ctl1_ff;
         // Blend along y
         vy_ff[0] <= blend(vx_ff[0], vx_ff[1], ctl2_ff.ty);
         vy_ff[1] <= blend(vx_ff[2], vx_ff[3], ctl2_ff.ty);
         ctl3_ff  <= ctl2_ff;
         // Blend along z into the output register
         value_ff  <= value_in;
         status_ff <= ctl3_ff.status;
      end
   end

   assign rsp_tvalid = valid_ff[3];
   assign rsp_tdata  = {1'b0, value_ff};
   assign rsp_tuser  = status_ff;

endmodule

/* rtl/trilinear_kernel_table_interp.sv */
// Top level of the trilinear kernel table interpolator.
// Stages are the front register, queue slot, bank read, x and y blends and output.
// Throughput: one item per cycle; eight parity banks give all corners in one read.
// The two-entry queue lets the front end take items while the back end stalls.
// Reset: synchronous, active high; clears pipeline valids and the table-loaded flag.
// Table contents are not cleared; a full load ends with the write to the last address.
`timescale 1ns / 1ps
module trilinear_kernel_table_interp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // entry_address[14:0], entry_value[38:15], x_coord[56:39], y_coord[74:57],
   // z_coord[92:75], zero pad [95:93]
   input  logic [95:0] req_tdata,
   // action[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // kernel_value[22:0], zero pad [23]
   output logic [23:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser
);
   import tkti_pkg::*;

   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;

   tkti_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   tkti_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   tkti_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/tkti_checker.sv */
// Port-level checks for the trilinear kernel table interpolator, with bind.
`timescale 1ns / 1ps
module tkti_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [95:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import tkti_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Only defined status codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK) || (rsp_tuser == STATUS_WRITE) ||
                     (rsp_tuser == STATUS_NOLOAD))
      else $error("undefined status");

   // Writes and errors report zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> (rsp_tdata == 24'd0))
      else $error("nonzero value on write or error");

   // Magnitude never exceeds one eighth
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[22:0]) <= 23'sd2097152) &&
                     ($signed(rsp_tdata[22:0]) >= -23'sd2097152) && !rsp_tdata[23])
      else $error("value out of range");

endmodule

bind trilinear_kernel_table_interp tkti_port_checks u_checker (.*);

/* bench/tkti_checker.sv */
// Checker for the trilinear kernel table interpolator: predicts results and compares them.
`timescale 1ns / 1ps
module tkti_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);
   import tkti_pkg::*;

   typedef struct packed {
      logic [22:0] kernel_value;
      status_type  status;
   } kernel_result_type;

   logic [23:0]        shadow_table [TABLE_DEPTH];
   logic               shadow_loaded;
   kernel_result_type  expected_results [$];

   // Clamped Q0.16 magnitude of a Q2.16 coordinate
   function automatic logic [16:0] clamp_mag(logic signed [17:0] c);
      logic [17:0] m;
      m = c[17] ? 18'(-c) : 18'(c);
      return (m > 18'(ONE_Q16)) ? ONE_Q16 : m[16:0];
   endfunction

   function automatic logic [23:0] mix(logic [23:0] a, logic [23:0] b, logic [16:0] t);
      logic [41:0] s;
      s = 42'(17'(ONE_Q16 - t)) * 42'(a) + 42'(t) * 42'(b);
      return s[39:16];
   endfunction

   function automatic logic [23:0] tap(int i, int j, int k);
      return shadow_table[i + GRID_POINTS * j + GRID_POINTS * GRID_POINTS * k];
   endfunction

   // Predict one result and update the shadow table
   function automatic kernel_result_type predict_kernel(logic [95:0] d, logic act);
      kernel_result_type r;
      logic [16:0] m [3];
      int base_ix [3];
      logic [16:0] fr [3];
      logic [23:0] v00, v10, v01, v11, v0, v1, mag;
      logic neg;
      int a;
      r = '0;
      if (!act) begin
         if (int'(d[14:0]) < TABLE_DEPTH) begin
            shadow_table[d[14:0]] = d[38:15];
            if (int'(d[14:0]) == TABLE_DEPTH - 1) shadow_loaded = 1'b1;
         end
         r.status = STATUS_WRITE;
         return r;
      end
      if (!shadow_loaded) begin
         r.status = STATUS_NOLOAD;
         return r;
      end
      neg = d[56] ^ d[74] ^ d[92];
      m[0] = clamp_mag(d[56:39]);
      m[1] = clamp_mag(d[74:57]);
      m[2] = clamp_mag(d[92:75]);
      if (m[0] == ONE_Q16 && m[1] == ONE_Q16 && m[2] == ONE_Q16) begin
         mag = EIGHTH_Q24;
      end else begin
         for (int n = 0; n < 3; n++) begin
            a = int'(m[n]) * (GRID_POINTS - 1);
            base_ix[n] = a >> 16;
            if (base_ix[n] > CELL_MAX) base_ix[n] = CELL_MAX;
            fr[n] = 17'(a - (base_ix[n] << 16));
         end
         v00 = mix(tap(base_ix[0], base_ix[1], base_ix[2]),
                   tap(base_ix[0]+1, base_ix[1], base_ix[2]), fr[0]);
         v10 = mix(tap(base_ix[0], base_ix[1]+1, base_ix[2]),
                   tap(base_ix[0]+1, base_ix[1]+1, base_ix[2]), fr[0]);
         v01 = mix(tap(base_ix[0], base_ix[1], base_ix[2]+1),
                   tap(base_ix[0]+1, base_ix[1], base_ix[2]+1), fr[0]);
         v11 = mix(tap(base_ix[0], base_ix[1]+1, base_ix[2]+1),
                   tap(base_ix[0]+1, base_ix[1]+1, base_ix[2]+1), fr[0]);
         v0 = mix(v00, v10, fr[1]);
         v1 = mix(v01, v11, fr[1]);
         mag = mix(v0, v1, fr[2]);
         if (mag > EIGHTH_Q24) mag = EIGHTH_Q24;
      end
      r.kernel_value = neg ? 23'(-mag) : mag[22:0];
      r.status = STATUS_OK;
      return r;
   endfunction

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      kernel_result_type want;
      if (reset) begin
         shadow_loaded = 1'b0;
         fail_count = 0;
         result_count = 0;
         expected_results.delete();
         pending_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected: value %h status %0d",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== {1'b0, want.kernel_value} || rsp_tuser !== want.status) begin
                  fail_count++;
                  $display("%0t: mismatch: expected value %h status %0d, got value %h status %0d",
                           $time, want.kernel_value, want.status, rsp_tdata, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_kernel(req_tdata, req_tuser[0]));
         pending_count = expected_results.size();
      end
   end

endmodule

/* bench/tb_trilinear_kernel_table_interp.sv */
// Testbench top for the trilinear kernel table interpolator: stimulus and verdict.
`timescale 1ns / 1ps
module tb_trilinear_kernel_table_interp;
   import tkti_pkg::*;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam int   STALL_LIMIT = 4000;
   localparam int   RANDOM_ITEMS = 1420;
   // Grid indices 0..2 and the top three form the loaded band
   localparam int   BAND_POINTS = 6;
   // Magnitudes that keep the cell base at 0..1 or at the top two cells
   localparam int   LOW_MAG  = (2 * 65536 - 1) / (GRID_POINTS - 1);
   localparam int   HIGH_MAG = ((GRID_POINTS - 3) * 65536 + GRID_POINTS - 2) / (GRID_POINTS - 1);

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          fail_count;
   int          pending_count;
   int          result_count;
   int          idle_cycles;
   int          query_count;
   bit          calm_phase;
   bit          hold_rsp;

   trilinear_kernel_table_interp dut (.*);

   tkti_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Pack one item; fields lowest first
   function automatic logic [95:0] pack_item(logic [14:0] addr, logic [23:0] value,
                                             logic [17:0] x, logic [17:0] y, logic [17:0] z);
      return {3'b000, z, y, x, value, addr};
   endfunction

   task automatic send_item(logic act, logic [95:0] d);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= d;
      if (act == ACT_QUERY) query_count++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Grid index of the n-th point of the loaded band
   function automatic int band_index(int n);
      return (n < BAND_POINTS / 2) ? n : GRID_POINTS - BAND_POINTS + n;
   endfunction

   // Table value: mostly up to one eighth, sometimes full scale
   function automatic logic [23:0] rand_value();
      return ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 2097152));
   endfunction

   // Coordinate whose cell lies inside the loaded band
   function automatic logic [17:0] rand_coord();
      int m;
      case ($urandom_range(0, 5))
         0: m = int'($urandom_range(0, LOW_MAG));
         1: m = -int'($urandom_range(0, LOW_MAG));
         2: m = int'($urandom_range(HIGH_MAG, 131071));
         3: m = -int'($urandom_range(HIGH_MAG, 131072));
         4: m = -131072;
         default: m = ($urandom_range(0, 1) == 0) ? 65536 : -65536;
      endcase
      return 18'(m);
   endfunction

   // Receiver: random stalls, one long hold-off, none at the end
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog on cycles with no handshake
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_WRITE;
      calm_phase = 1'b0;
      hold_rsp = 1'b0;
      query_count = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Query before load, edge coordinates
      send_item(ACT_QUERY, pack_item('0, '0, 18'h1FFFF, 18'h20000, '0));
      send_item(ACT_QUERY, pack_item(15'h7FFF, 24'hFFFFFF, '0, '0, '0));
      // Write to the last address ahead of the load
      send_item(ACT_WRITE, pack_item(15'h7FFF, 24'hFFFFFF, '0, '0, '0));
      // Long receiver hold-off while the band loads; the last address goes last
      hold_rsp = 1'b1;
      for (int k = 0; k < BAND_POINTS; k++)
         for (int j = 0; j < BAND_POINTS; j++)
            for (int i = 0; i < BAND_POINTS; i++)
               send_item(ACT_WRITE, pack_item(15'(band_index(i) + GRID_POINTS * band_index(j) +
                         GRID_POINTS * GRID_POINTS * band_index(k)), rand_value(),
                         '0, '0, '0));

      // Directed queries: corners, clamps, minus two, saturation, sign cases
      send_item(ACT_QUERY, pack_item('0, '0, '0, '0, '0));
      send_item(ACT_QUERY, pack_item('0, '0, 18'h10000, 18'h10000, 18'h10000));
      send_item(ACT_QUERY, pack_item('0, '0, 18'h20000, 18'h1FFFF, 18'h30000));
      send_item(ACT_QUERY, pack_item('0, '0, 18'h20000, '0, '0));
      send_item(ACT_QUERY, pack_item('0, '0, 18'h0FFFF, 18'h0FFFF, 18'h0FFFF));
      send_item(ACT_QUERY, pack_item('0, '0, 18'h3FFFF, '0, '0));
      send_item(ACT_QUERY, pack_item('0, '0, 18'h3FFFF, 18'h3FFFF, '0));
      send_item(ACT_QUERY, pack_item('0, '0, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF));
      send_item(ACT_QUERY, pack_item('0, '0, 18'h00800, 18'h3F000, 18'h01034));
      // Rewrite after load, then query over it
      send_item(ACT_WRITE, pack_item('0, 24'h000000, '0, '0, '0));
      send_item(ACT_WRITE, pack_item(15'h7FFF, 24'h123456, '0, '0, '0));
      send_item(ACT_QUERY, pack_item('0, '0, '0, '0, '0));

      // Random mix: mostly queries, some rewrites
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - 200) calm_phase = 1'b1;
         if ($urandom_range(0, 9) == 0)
            send_item(ACT_WRITE, pack_item(15'($urandom), rand_value(), 18'($urandom),
                      18'($urandom), 18'($urandom)));
         else
            send_item(ACT_QUERY, pack_item(15'($urandom), 24'($urandom), rand_coord(),
                      rand_coord(), rand_coord()));
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Run covered pre-load errors, a band load under a held receiver,");
      $display("%0d queries and %0d results with random stalls.", query_count, result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
